### sv/sgrg_pkg.sv
// shared types, font table and helper functions for the scaled glyph row generator
`default_nettype none

package sgrg_pkg;

  // largest magnification and the widths that follow from it
  localparam int unsigned MaxScale = 8;
  localparam int unsigned ScaleW   = $clog2(MaxScale + 1);
  localparam int unsigned MaskW    = 3 * MaxScale;

  // font geometry
  localparam int unsigned GlyphW    = 4;
  localparam int unsigned RowW      = 3;
  localparam int unsigned FontRows  = 5;
  localparam logic [RowW-1:0] RowLast = RowW'(FontRows - 1);

  // glyph codes
  localparam logic [GlyphW-1:0] GlyphF    = 4'd10;
  localparam logic [GlyphW-1:0] GlyphP    = 4'd11;
  localparam logic [GlyphW-1:0] GlyphS    = 4'd12;
  localparam logic [GlyphW-1:0] GlyphNone = 4'd15;

  // configuration register indexes
  localparam logic CfgScale = 1'b0;
  localparam logic CfgInk   = 1'b1;

  typedef enum logic [0:0] {
    StIdle,
    StEmit
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_glyph;
    logic last_span;
    logic out_free;
  } dp_status_t;

  // character code to glyph index
  function automatic logic [GlyphW-1:0] glyph_of(input logic [7:0] c);
    logic [GlyphW-1:0] g;
    g = GlyphNone;
    if (c >= 8'h30 && c <= 8'h39) begin
      g = GlyphW'(c - 8'h30);
    end else if (c == 8'h46 || c == 8'h66) begin
      g = GlyphF;
    end else if (c == 8'h50 || c == 8'h70) begin
      g = GlyphP;
    end else if (c == 8'h53 || c == 8'h73) begin
      g = GlyphS;
    end
    return g;
  endfunction

  // one 3-bit row of the font, msb is the leftmost column
  function automatic logic [2:0] font_row(input logic [GlyphW-1:0] g,
                                          input logic [RowW-1:0] r);
    logic [14:0] rows;
    logic [2:0]  bits;
    unique case (g)
      4'd0:    rows = {3'b111, 3'b101, 3'b101, 3'b101, 3'b111};
      4'd1:    rows = {3'b010, 3'b110, 3'b010, 3'b010, 3'b111};
      4'd2:    rows = {3'b111, 3'b001, 3'b111, 3'b100, 3'b111};
      4'd3:    rows = {3'b111, 3'b001, 3'b111, 3'b001, 3'b111};
      4'd4:    rows = {3'b101, 3'b101, 3'b111, 3'b001, 3'b001};
      4'd5:    rows = {3'b111, 3'b100, 3'b111, 3'b001, 3'b111};
      4'd6:    rows = {3'b111, 3'b100, 3'b111, 3'b101, 3'b111};
      4'd7:    rows = {3'b111, 3'b001, 3'b010, 3'b010, 3'b010};
      4'd8:    rows = {3'b111, 3'b101, 3'b111, 3'b101, 3'b111};
      4'd9:    rows = {3'b111, 3'b101, 3'b111, 3'b001, 3'b111};
      GlyphF:  rows = {3'b111, 3'b100, 3'b110, 3'b100, 3'b100};
      GlyphP:  rows = {3'b111, 3'b101, 3'b111, 3'b100, 3'b100};
      GlyphS:  rows = {3'b111, 3'b100, 3'b111, 3'b001, 3'b111};
      default: rows = '0;
    endcase
    unique case (r)
      3'd0:    bits = rows[14:12];
      3'd1:    bits = rows[11:9];
      3'd2:    bits = rows[8:6];
      3'd3:    bits = rows[5:3];
      3'd4:    bits = rows[2:0];
      default: bits = '0;
    endcase
    return bits;
  endfunction

  // repeat each font column s times, leftmost column in the low bits
  function automatic logic [MaskW-1:0] widen_row(input logic [2:0] bits,
                                                 input logic [ScaleW-1:0] s);
    logic [MaskW-1:0] m;
    logic [ScaleW+1:0] s1;
    logic [ScaleW+1:0] s2;
    logic [ScaleW+1:0] s3;
    s1 = (ScaleW + 2)'(s);
    s2 = s1 + s1;
    s3 = s2 + s1;
    for (int unsigned i = 0; i < MaskW; i++) begin
      if ((ScaleW + 2)'(i) < s1) begin
        m[i] = bits[2];
      end else if ((ScaleW + 2)'(i) < s2) begin
        m[i] = bits[1];
      end else if ((ScaleW + 2)'(i) < s3) begin
        m[i] = bits[0];
      end else begin
        m[i] = 1'b0;
      end
    end
    return m;
  endfunction

  // clamp a written scale to 1..MaxScale
  function automatic logic [ScaleW-1:0] eff_scale(input logic [3:0] s);
    logic [ScaleW-1:0] e;
    if (s == 4'd0) begin
      e = ScaleW'(1);
    end else if (32'(s) > MaxScale) begin
      e = ScaleW'(MaxScale);
    end else begin
      e = ScaleW'(s);
    end
    return e;
  endfunction

endpackage

`default_nettype wire

### sv/sgrg_ctrl.sv
// controller state machine: accepts a character, then sequences the spans of a glyph character
`default_nettype none

module sgrg_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sgrg_pkg::dp_status_t status_i,
  output sgrg_pkg::dp_cmd_t        cmd_o,
  output logic                     busy_o
);

  sgrg_pkg::ctrl_state_e state_q, state_d;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgrg_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sgrg_pkg::StIdle: begin
        if (accept && status_i.in_glyph) state_d = sgrg_pkg::StEmit;
      end
      sgrg_pkg::StEmit: begin
        if (status_i.out_free && status_i.last_span) state_d = sgrg_pkg::StIdle;
      end
      default: state_d = sgrg_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      sgrg_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = accept;
      end
      sgrg_pkg::StEmit: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign busy_o = (state_q == sgrg_pkg::StEmit);

endmodule

`default_nettype wire

### sv/sgrg_dp.sv
// datapath: config registers, cursor, span counters and the output register
`default_nettype none

module sgrg_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [31:0]         cfg_data_i,
  // input item fields
  input  wire logic [7:0]          char_code_i,
  input  wire logic                string_start_i,
  input  wire logic [15:0]         start_x_i,
  input  wire logic [15:0]         start_y_i,
  // control
  input  wire sgrg_pkg::dp_cmd_t   cmd_i,
  output sgrg_pkg::dp_status_t     status_o,
  // result item
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [15:0]              span_x_o,
  output logic [15:0]              span_y_o,
  output logic [sgrg_pkg::MaskW-1:0] row_mask_o,
  output logic [31:0]              color_out_o,
  output logic                     last_row_o
);

  localparam int unsigned ScaleW = sgrg_pkg::ScaleW;
  localparam int unsigned RowW   = sgrg_pkg::RowW;

  logic [3:0]  scale_cfg_q;
  logic [31:0] ink_q;
  logic [15:0] cursor_x_q, cursor_x_d;
  logic [15:0] text_row_y_q;
  logic [15:0] draw_x_q;
  logic [15:0] y_q;
  logic [sgrg_pkg::GlyphW-1:0] glyph_q;
  logic [ScaleW-1:0] scale_q;
  logic [RowW-1:0]   row_q;
  logic [ScaleW-1:0] sub_q;
  logic              out_valid_q;

  logic [ScaleW-1:0] scale_now;
  logic [15:0]       base_x, base_y;
  logic              sub_last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_cfg_q <= 4'd1;
      ink_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sgrg_pkg::CfgScale: scale_cfg_q <= cfg_data_i[3:0];
        sgrg_pkg::CfgInk:   ink_q       <= cfg_data_i;
        default:            ink_q       <= ink_q;
      endcase
    end
  end

  // start coordinates and cursor advance
  assign scale_now  = sgrg_pkg::eff_scale(scale_cfg_q);
  assign base_x     = string_start_i ? start_x_i : cursor_x_q;
  assign base_y     = string_start_i ? start_y_i : text_row_y_q;
  assign cursor_x_d = base_x + {{(14 - ScaleW){1'b0}}, scale_now, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      text_row_y_q <= '0;
    end else if (cmd_i.load) begin
      cursor_x_q   <= cursor_x_d;
      text_row_y_q <= base_y;
    end
  end

  // span sequencing: y just counts up one per span
  assign sub_last = (sub_q == scale_q - ScaleW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      draw_x_q <= base_x;
      y_q      <= base_y;
      glyph_q  <= sgrg_pkg::glyph_of(char_code_i);
      scale_q  <= scale_now;
      row_q    <= '0;
      sub_q    <= '0;
    end else if (cmd_i.emit) begin
      y_q <= y_q + 16'd1;
      if (sub_last) begin
        sub_q <= '0;
        row_q <= row_q + RowW'(1);
      end else begin
        sub_q <= sub_q + ScaleW'(1);
      end
    end
  end

  // output register, payload loaded on each emitted span
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      span_x_o    <= draw_x_q;
      span_y_o    <= y_q;
      row_mask_o  <= sgrg_pkg::widen_row(sgrg_pkg::font_row(glyph_q, row_q), scale_q);
      color_out_o <= ink_q;
      last_row_o  <= status_o.last_span;
    end
  end

  // status to the controller
  assign status_o.in_glyph  = (sgrg_pkg::glyph_of(char_code_i) != sgrg_pkg::GlyphNone);
  assign status_o.last_span = (row_q == sgrg_pkg::RowLast) && sub_last;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;

endmodule

`default_nettype wire

### sv/scaled_glyph_row_generator.sv
// top level of the scaled glyph row generator
`default_nettype none

// Draws one character per input item in a 3x5 font (digits, F, P, S in either
// case), magnified by the clamped scale_factor s (1..8). A glyph character is
// accepted, then the span sequencer puts one span per cycle into the output
// register, 5*s spans from top to bottom with tlast on the final one; an output
// stall holds the sequencer. A character outside the font is accepted and emits
// nothing. The cursor advances by 4*s after every character; coordinates wrap at
// 16 bits. The next character is accepted while the final span still waits in
// the output register.
module scaled_glyph_row_generator (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  // character items
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [39:0]  s_axis_tdata,  // char_code, start_x, start_y
  input  wire logic [0:0]   s_axis_tuser,  // string_start
  // span items
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [87:0]       m_axis_tdata,  // span_x, span_y, row_mask, color_out
  output logic              m_axis_tlast   // last_row
);

  sgrg_pkg::dp_cmd_t    cmd;
  sgrg_pkg::dp_status_t status;
  logic                 busy;

  logic [15:0]               span_x;
  logic [15:0]               span_y;
  logic [sgrg_pkg::MaskW-1:0] row_mask;
  logic [31:0]               color_out;

  sgrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  sgrg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .char_code_i    (s_axis_tdata[7:0]),
    .string_start_i (s_axis_tuser[0]),
    .start_x_i      (s_axis_tdata[23:8]),
    .start_y_i      (s_axis_tdata[39:24]),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .span_x_o       (span_x),
    .span_y_o       (span_y),
    .row_mask_o     (row_mask),
    .color_out_o    (color_out),
    .last_row_o     (m_axis_tlast)
  );

  // pack the span item
  assign m_axis_tdata = {color_out, row_mask, span_y, span_x};

  // no new character while spans are still being sequenced
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("character accepted while spans pending");

  // a glyph character starts span sequencing
  a_glyph_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && status.in_glyph) |=> busy)
    else $error("glyph accepted without sequencing spans");

  // a new span only appears while sequencing
  a_span_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)) |-> $past(busy))
    else $error("span item appeared outside sequencing");

  // leaving sequencing coincides with loading the final span
  a_last_on_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (m_axis_tvalid && m_axis_tlast))
    else $error("sequencing ended without final span");

endmodule

`default_nettype wire
